### src/lkvc_pkg.sv
// shared types and constants for the lru key-value cache
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic             REQ_GET   = 1'b0;
    localparam logic             REQ_PUT   = 1'b1;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [VAL_W-1:0] MISS_VAL  = {VAL_W{1'b1}};
    localparam logic [VAL_W-1:0] PUT_VAL   = {VAL_W{1'b0}};

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] lookup_key;
        logic [VAL_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } rsp_t;

endpackage

### src/lkvc_store.sv
// entry store: parallel key match, age rank update, eviction and insert
`timescale 1ns / 1ps

module lkvc_store #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  logic [lkvc_pkg::CAP_W-1:0] cap_limit,
    input  logic                      req_en,
    input  lkvc_pkg::req_t            req,
    output lkvc_pkg::rsp_t            rsp
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

    logic [MAX_ENTRIES-1:0]           valid_reg;
    logic [MAX_ENTRIES-1:0]           valid_next;
    logic [CNT_W-1:0]                 live_count_reg;
    logic [CNT_W-1:0]                 live_count_next;
    logic [lkvc_pkg::KEY_W-1:0]       slot_key_reg  [MAX_ENTRIES];
    logic [lkvc_pkg::VAL_W-1:0]       slot_data_reg [MAX_ENTRIES];
    logic [IDX_W-1:0]                 slot_rank_reg [MAX_ENTRIES];
    logic [IDX_W-1:0]                 slot_rank_next[MAX_ENTRIES];

    logic [MAX_ENTRIES-1:0] match;
    logic [MAX_ENTRIES-1:0] evict_mask;
    logic [MAX_ENTRIES-1:0] valid_kept;
    logic                   found;
    logic [IDX_W-1:0]       found_idx;
    logic [IDX_W-1:0]       free_idx;
    logic [IDX_W-1:0]       hit_rank;
    logic [IDX_W-1:0]       oldest_rank;
    logic [CNT_W-1:0]       live_m1;
    logic [CMP_W-1:0]       cap_ext;
    logic [CMP_W-1:0]       cap_eff;
    logic [CMP_W-1:0]       live_ext;
    logic                   full;
    logic                   is_put;
    logic                   do_touch;
    logic                   do_insert;

    // effective capacity: zero acts as one, saturate at the entry count
    always_comb
    begin
        cap_ext = CMP_W'(cap_limit);
        if (cap_ext == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(MAX_ENTRIES))
        begin
            cap_eff = CMP_W'(MAX_ENTRIES);
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end

    assign live_ext    = CMP_W'(live_count_reg);
    assign full        = (live_ext >= cap_eff);
    assign live_m1     = live_count_reg - CNT_W'(1);
    assign oldest_rank = live_m1[IDX_W-1:0];
    assign is_put      = (req.req_type == lkvc_pkg::REQ_PUT);

    // key match and priority select
    always_comb
    begin
        found_idx = '0;
        free_idx  = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            match[i]      = valid_reg[i] && (slot_key_reg[i] == req.lookup_key);
            evict_mask[i] = full && valid_reg[i] && (slot_rank_reg[i] == oldest_rank);
        end
        valid_kept = valid_reg & ~evict_mask;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                found_idx = IDX_W'(i);
            end
            if (!valid_kept[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign found     = |match;
    assign hit_rank  = slot_rank_reg[found_idx];
    assign do_touch  = req_en && found;
    assign do_insert = req_en && is_put && !found;

    always_comb
    begin
        rsp.hit = found;
        if (is_put)
        begin
            rsp.read_value = lkvc_pkg::PUT_VAL;
        end
        else if (found)
        begin
            rsp.read_value = slot_data_reg[found_idx];
        end
        else
        begin
            rsp.read_value = lkvc_pkg::MISS_VAL;
        end
    end

    // next valid bits, count and ranks
    always_comb
    begin
        valid_next      = valid_reg;
        live_count_next = live_count_reg;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            slot_rank_next[i] = slot_rank_reg[i];
        end
        if (clear)
        begin
            valid_next      = '0;
            live_count_next = '0;
        end
        else if (do_touch)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (IDX_W'(i) == found_idx)
                begin
                    slot_rank_next[i] = '0;
                end
                else if (valid_reg[i] && (slot_rank_reg[i] < hit_rank))
                begin
                    slot_rank_next[i] = slot_rank_reg[i] + IDX_W'(1);
                end
            end
        end
        else if (do_insert)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                if (IDX_W'(i) == free_idx)
                begin
                    slot_rank_next[i] = '0;
                end
                else if (valid_kept[i])
                begin
                    slot_rank_next[i] = slot_rank_reg[i] + IDX_W'(1);
                end
            end
            valid_next           = valid_kept;
            valid_next[free_idx] = 1'b1;
            if (!full)
            begin
                live_count_next = live_count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            live_count_reg <= '0;
        end
        else
        begin
            valid_reg      <= valid_next;
            live_count_reg <= live_count_next;
        end
    end

    // entry payload, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            slot_rank_reg[i] <= slot_rank_next[i];
        end
        if (!clear && do_insert)
        begin
            slot_key_reg[free_idx]  <= req.lookup_key;
            slot_data_reg[free_idx] <= req.write_value;
        end
        else if (!clear && do_touch && is_put)
        begin
            slot_data_reg[found_idx] <= req.write_value;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(live_count_reg))
        else $error("live count differs from number of valid entries");

    assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(live_count_reg) <= CMP_W'(MAX_ENTRIES))
        else $error("live count above entry count");

    assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (live_count_reg == '0) && (valid_reg == '0))
        else $error("store not empty after clear");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!clear && do_insert && !full) |=> live_count_reg == $past(live_count_reg) + CNT_W'(1))
        else $error("insert without eviction did not grow the store");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!clear && req_en) |-> $onehot0(match))
        else $error("key present in more than one entry");

endmodule

### src/lru_key_value_cache_core.sv
// top level of the lru key-value cache: stream ports, capacity register, beat registers
`timescale 1ns / 1ps

// Fully associative key-value cache with least-recently-used replacement.
// One request beat is accepted every clock cycle while the result side keeps up.
// Its result beat passes through the input register and then the result register
// before it is valid on the master side. All entries are key-compared in
// parallel and their age ranks updated combinationally between those two
// registers, which allows one request per cycle while the result side keeps up.
// Writing the capacity empties the store in the cycle after the write; there is
// no clearing pass after reset. Write the capacity only while no beat is in flight.

module lru_key_value_cache_core #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0]  cfg_wr_data,  // capacity_limit
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,      // lookup_key, write_value
    input  logic                        s_tuser,      // req_type
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,      // read_value
    output logic                        m_tuser       // hit
);

    logic                       cap_write;
    logic [lkvc_pkg::CAP_W-1:0] cap_limit_reg;
    logic                       in_valid_reg;
    lkvc_pkg::req_t             in_req_reg;
    logic                       out_valid_reg;
    lkvc_pkg::rsp_t             out_rsp_reg;
    lkvc_pkg::rsp_t             store_rsp;
    logic                       advance;

    assign cap_write = cfg_wr_en;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_limit_reg <= lkvc_pkg::CAP_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cap_write)
            begin
                cap_limit_reg <= cfg_wr_data;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // beat payload
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_req_reg.req_type    <= s_tuser;
            in_req_reg.lookup_key  <= s_tdata[31:0];
            in_req_reg.write_value <= s_tdata[63:32];
        end
        if (advance)
        begin
            out_rsp_reg <= store_rsp;
        end
    end

    lkvc_store #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (cap_write),
        .cap_limit (cap_limit_reg),
        .req_en    (advance),
        .req       (in_req_reg),
        .rsp       (store_rsp)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_rsp_reg.read_value;
    assign m_tuser  = out_rsp_reg.hit;

endmodule
